### sv/zgfs_pkg.sv
// ----------------------------------------------------------------------------
// zgfs_pkg
// Shared types, sizes and helpers for the gray frame store with depth buffer.
// ----------------------------------------------------------------------------
package zgfs_pkg;

    // frame store geometry
    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 128;
    localparam int DEPTH_BITS  = 24;
    localparam int STORE_SIZE  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = $clog2(STORE_SIZE);
    localparam int CNT_BITS    = $clog2(STORE_SIZE + 1);
    localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int X_BITS      = $clog2(MAX_WIDTH);
    localparam int Y_BITS      = $clog2(MAX_HEIGHT);

    // farthest depth code
    localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = '1;

    // field widths
    localparam int POS_BITS         = 16;
    localparam int PIXEL_DEPTH_BITS = 24;
    localparam int GRAY_BITS        = 8;
    localparam int CODE_BITS        = 8;

    // configuration registers
    localparam int CFG_WIDTH_BITS  = 9;
    localparam int CFG_HEIGHT_BITS = 8;
    localparam int CFG_DATA_BITS   = 9;
    localparam int CFG_INDEX_BITS  = 1;
    localparam logic [CFG_INDEX_BITS-1:0]  CFG_FRAME_WIDTH    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0]  CFG_FRAME_HEIGHT   = 1'd1;
    localparam logic [CFG_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 8'd128;

    // terminal gray ramp
    localparam int GRAY_CODE_BASE  = 232;
    localparam int GRAY_CODE_STEPS = 23;

    typedef enum logic [1:0] {
        MODE_WRITE     = 2'd0,
        MODE_CLR_GRAY  = 2'd1,
        MODE_CLR_DEPTH = 2'd2,
        MODE_READ      = 2'd3
    } zgfs_mode_t;

    typedef struct packed {
        zgfs_mode_t                   mode;
        logic signed [POS_BITS-1:0]   pos_x;
        logic signed [POS_BITS-1:0]   pos_y;
        logic [PIXEL_DEPTH_BITS-1:0]  pixel_depth;
        logic [GRAY_BITS-1:0]         gray_value;
    } zgfs_in_t;

    typedef struct packed {
        logic                 status;
        logic                 stored;
        logic [CODE_BITS-1:0] top_code;
        logic [CODE_BITS-1:0] bottom_code;
    } zgfs_out_t;

    // controller to datapath
    typedef struct packed {
        logic init_step;
        logic capture;
        logic calc_prod;
        logic calc_addr;
        logic sweep_start;
        logic sweep_step;
        logic rd_top;
        logic rd_bot;
        logic try_write;
        logic take_top;
        logic take_bot;
        logic load_result;
    } zgfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        zgfs_mode_t mode;
        logic       range_ok;
        logic       sweep_done;
        logic       init_last;
    } zgfs_stat_t;

    // 232 + floor(v * 23 / 255); the divide by 255 is a shift with a
    // 1/256 correction, exact in this 16-bit arithmetic for products below 65280
    function automatic logic [CODE_BITS-1:0] gray_to_code(input logic [GRAY_BITS-1:0] v);
        logic [15:0] prod;
        logic [15:0] quot;
        prod = 16'(v) * 16'(GRAY_CODE_STEPS);
        quot = (prod + (prod >> 8) + 16'd1) >> 8;
        return CODE_BITS'(GRAY_CODE_BASE) + quot[CODE_BITS-1:0];
    endfunction

endpackage

### sv/zgfs_ctrl.sv
// ----------------------------------------------------------------------------
// zgfs_ctrl
// Sequencer for the frame store: power-up clear, per-item operation steps
// and the output beat handshake.
// ----------------------------------------------------------------------------
module zgfs_ctrl
    import zgfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  zgfs_stat_t stat,
    output zgfs_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_ADDR,
        S_FETCH,
        S_CHECK,
        S_BOTTOM,
        S_CLEAR,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // input side only open while idle
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_ADDR;
            end
            S_ADDR:
            begin
                if (stat.mode == MODE_CLR_GRAY || stat.mode == MODE_CLR_DEPTH)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_CLEAR;
                end
                else if (stat.range_ok)
                begin
                    cmd.calc_addr = 1'b1;
                    state_next    = S_FETCH;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FETCH:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.mode == MODE_WRITE)
                begin
                    cmd.try_write = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.take_top = 1'b1;
                    cmd.rd_bot   = 1'b1;
                    state_next   = S_BOTTOM;
                end
            end
            S_BOTTOM:
            begin
                cmd.take_bot = 1'b1;
                state_next   = S_OUT;
            end
            S_CLEAR:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/zgfs_datapath.sv
// ----------------------------------------------------------------------------
// zgfs_datapath
// Configuration registers, item registers, index multiplier, gray and depth
// memories with the depth test, clear sweep counter and result register.
// ----------------------------------------------------------------------------
module zgfs_datapath
    import zgfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  zgfs_in_t                  in_data,
    input  zgfs_cmd_t                 cmd,
    output zgfs_stat_t                stat,
    output zgfs_out_t                 out_data
);

    logic [CFG_WIDTH_BITS-1:0]  frame_width_reg;
    logic [CFG_HEIGHT_BITS-1:0] frame_height_reg;
    logic [WIDTH_BITS-1:0]      eff_w;
    logic [HEIGHT_BITS-1:0]     eff_h;

    zgfs_mode_t                 mode_reg;
    logic [POS_BITS-1:0]        x_reg;
    logic [POS_BITS-1:0]        y_reg;
    logic [DEPTH_BITS-1:0]      depth_reg;
    logic [GRAY_BITS-1:0]       gray_reg;

    logic                       x_ok;
    logic                       y_ok;
    logic [POS_BITS:0]          y_last;
    logic                       range_ok_reg;
    logic [HEIGHT_BITS-1:0]     mul_a;
    logic [WIDTH_BITS+HEIGHT_BITS-1:0] product;
    logic [CNT_BITS-1:0]        prod_reg;
    logic [ADDR_BITS-1:0]       addr_reg;
    logic [ADDR_BITS-1:0]       bot_addr_reg;
    logic [CNT_BITS-1:0]        sweep_cnt_reg;

    logic [GRAY_BITS-1:0]       gray_mem [STORE_SIZE];
    logic [DEPTH_BITS-1:0]      depth_mem [STORE_SIZE];
    logic [GRAY_BITS-1:0]       gray_rd_reg;
    logic [DEPTH_BITS-1:0]      depth_rd_reg;

    logic                       sweep_write;
    logic                       closer;
    logic                       gray_we;
    logic                       depth_we;
    logic [ADDR_BITS-1:0]       wr_addr;
    logic [ADDR_BITS-1:0]       rd_addr;
    logic [GRAY_BITS-1:0]       gray_wdata;
    logic [DEPTH_BITS-1:0]      depth_wdata;

    logic                       stored_reg;
    logic [CODE_BITS-1:0]       top_reg;
    logic [CODE_BITS-1:0]       bot_reg;
    logic                       status_bit;
    zgfs_out_t                  out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // oversized frame clamps to the store size
    assign eff_w = (32'(frame_width_reg) > MAX_WIDTH) ? WIDTH_BITS'(MAX_WIDTH)
                                                      : WIDTH_BITS'(frame_width_reg);
    assign eff_h = (32'(frame_height_reg) > MAX_HEIGHT) ? HEIGHT_BITS'(MAX_HEIGHT)
                                                        : HEIGHT_BITS'(frame_height_reg);

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= in_data.mode;
            x_reg     <= in_data.pos_x;
            y_reg     <= in_data.pos_y;
            depth_reg <= DEPTH_BITS'(in_data.pixel_depth);
            gray_reg  <= in_data.gray_value;
        end
    end

    // bounds check, pair read needs row y+1 inside too
    assign y_last = (mode_reg == MODE_READ) ? {2'b00, y_reg[POS_BITS-2:0]} + (POS_BITS+1)'(1)
                                            : {2'b00, y_reg[POS_BITS-2:0]};
    assign x_ok   = !x_reg[POS_BITS-1] && (POS_BITS'(x_reg[POS_BITS-2:0]) < POS_BITS'(eff_w));
    assign y_ok   = !y_reg[POS_BITS-1] && (y_last < (POS_BITS+1)'(eff_h));

    // shared multiplier: row times width, or height times width for clears
    assign mul_a   = (mode_reg == MODE_CLR_GRAY || mode_reg == MODE_CLR_DEPTH)
                   ? eff_h : HEIGHT_BITS'(y_reg[Y_BITS-1:0]);
    assign product = mul_a * eff_w;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_prod)
        begin
            prod_reg     <= CNT_BITS'(product);
            range_ok_reg <= x_ok && y_ok;
        end
        if (cmd.calc_addr)
        begin
            addr_reg <= ADDR_BITS'(prod_reg) + ADDR_BITS'(x_reg[X_BITS-1:0]);
        end
        if (cmd.rd_top)
        begin
            bot_addr_reg <= addr_reg + ADDR_BITS'(eff_w);
        end
    end

    // sweep counter for power-up clear and clear operations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_start)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.init_step || cmd.sweep_step)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + CNT_BITS'(1);
        end
    end

    // memory write port selection
    assign sweep_write = cmd.init_step || cmd.sweep_step;
    assign closer      = depth_reg < depth_rd_reg;
    assign gray_we     = cmd.init_step
                       || (cmd.sweep_step && mode_reg == MODE_CLR_GRAY)
                       || (cmd.try_write && closer);
    assign depth_we    = cmd.init_step
                       || (cmd.sweep_step && mode_reg == MODE_CLR_DEPTH)
                       || (cmd.try_write && closer);
    assign wr_addr     = sweep_write ? sweep_cnt_reg[ADDR_BITS-1:0] : addr_reg;
    assign rd_addr     = cmd.rd_bot ? bot_addr_reg : addr_reg;
    assign gray_wdata  = cmd.try_write ? gray_reg : '0;
    assign depth_wdata = cmd.try_write ? depth_reg : DEPTH_FAR;

    // gray memory
    always_ff @(posedge clk)
    begin
        if (gray_we)
        begin
            gray_mem[wr_addr] <= gray_wdata;
        end
        if (cmd.rd_top || cmd.rd_bot)
        begin
            gray_rd_reg <= gray_mem[rd_addr];
        end
    end

    // depth memory
    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[wr_addr] <= depth_wdata;
        end
        if (cmd.rd_top)
        begin
            depth_rd_reg <= depth_mem[addr_reg];
        end
    end

    // per-item result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stored_reg <= 1'b0;
            top_reg    <= '0;
            bot_reg    <= '0;
        end
        else
        begin
            if (cmd.try_write)
            begin
                stored_reg <= closer;
            end
            if (cmd.take_top)
            begin
                top_reg <= gray_to_code(gray_rd_reg);
            end
            if (cmd.take_bot)
            begin
                bot_reg <= gray_to_code(gray_rd_reg);
            end
        end
    end

    // output register
    assign status_bit = (mode_reg == MODE_WRITE || mode_reg == MODE_READ) && !range_ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg.status      <= status_bit;
            out_data_reg.stored      <= stored_reg;
            out_data_reg.top_code    <= top_reg;
            out_data_reg.bottom_code <= bot_reg;
        end
    end

    assign out_data = out_data_reg;

    // status to controller
    assign stat.mode       = mode_reg;
    assign stat.range_ok   = range_ok_reg;
    assign stat.sweep_done = (sweep_cnt_reg == prod_reg);
    assign stat.init_last  = (sweep_cnt_reg == CNT_BITS'(STORE_SIZE - 1));

endmodule

### sv/zbuffered_gray_frame_store.sv
// ----------------------------------------------------------------------------
// zbuffered_gray_frame_store
// Gray frame store with a depth buffer: depth-tested pixel writes, gray and
// depth clears, and row-pair reads returned as terminal gray codes.
// ----------------------------------------------------------------------------
// one item at a time, one beat per item; the single read and write port of
// each memory and the registered index multiplier set the steps: a pixel
// write runs multiply, address, fetch and check states, a pair read adds a
// second gray read, an out-of-range write or read skips to the result, and a
// clear sweeps W*H entries (one entry per cycle); after reset the block clears
// both stores in full and takes no item until that pass ends, configuration writes are taken throughout
module zbuffered_gray_frame_store
    import zgfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  zgfs_in_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output zgfs_out_t                 out_data
);

    zgfs_cmd_t  cmd;
    zgfs_stat_t stat;

    // sequencer
    zgfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // storage and arithmetic
    zgfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // one item at a time: an accepted beat closes the input side
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an accepted beat");

    // a result is only loaded into a free or draining output register
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!out_valid || !out_stall))
        else $error("result loaded over a stalled beat");

    // a loaded result shows on the output next cycle
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |=> out_valid)
        else $error("loaded result not presented");

    // sweeps and depth-tested writes never share the write port
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !((cmd.sweep_step || cmd.init_step) && cmd.try_write))
        else $error("sweep and pixel write in the same cycle");

endmodule

### sim/zbuffered_gray_frame_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zbuffered_gray_frame_store_tb
// Self-checking bench for the gray frame store with depth buffer. Stimulus
// beats are queued by a sequencer, sent by a clocked driver and mirrored into
// a local frame/depth model at acceptance; a clocked monitor compares every
// result beat field by field against the oldest predicted one. The run walks
// through several frame sizes (zero, tiny, oversized, full) with random
// sender/receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module zbuffered_gray_frame_store_tb;
    import zgfs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int BIG_FRAME   = 2048;
    localparam int DRAIN_WAIT  = 40;

    // idling profiles
    typedef enum int {
        PACE_RECV_HEAVY,
        PACE_SEND_HEAVY,
        PACE_FREE
    } pace_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    zgfs_in_t                  in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    zgfs_out_t                 out_data;

    // local copy of the frame, depth buffer and size registers
    logic [GRAY_BITS-1:0]  gray_model  [STORE_SIZE];
    logic [DEPTH_BITS-1:0] depth_model [STORE_SIZE];
    int                    cfg_width;
    int                    cfg_height;

    zgfs_in_t  pending_beats[$];
    zgfs_out_t expected_results[$];
    int        beats_queued    = 0;
    int        beats_accepted  = 0;
    int        error_count     = 0;
    int        cycle_count     = 0;
    int        big_clears_left = 0;
    int        hold_request    = 0;
    pace_t     pace            = PACE_RECV_HEAVY;

    zbuffered_gray_frame_store u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // clock
    always #5 clk = ~clk;

    // effective frame size after clamping
    function automatic int cols_in_use();
        return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
    endfunction

    function automatic int rows_in_use();
        return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    endfunction

    // terminal gray ramp code
    function automatic logic [CODE_BITS-1:0] ramp_code(input logic [GRAY_BITS-1:0] v);
        return CODE_BITS'(GRAY_CODE_BASE + (int'(v) * GRAY_CODE_STEPS) / 255);
    endfunction

    // apply one beat to the local frame and return the expected result
    function automatic zgfs_out_t apply_to_frame(input zgfs_in_t beat);
        zgfs_out_t             res;
        int                    x;
        int                    y;
        int                    w;
        int                    h;
        int                    idx;
        logic [DEPTH_BITS-1:0] d;
        res = '0;
        x   = $signed(beat.pos_x);
        y   = $signed(beat.pos_y);
        w   = cols_in_use();
        h   = rows_in_use();
        d   = beat.pixel_depth[DEPTH_BITS-1:0];
        case (beat.mode)
            MODE_WRITE:
            begin
                if (x < 0 || x >= w || y < 0 || y >= h)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    idx = y * w + x;
                    // strict depth test
                    if (d < depth_model[idx])
                    begin
                        depth_model[idx] = d;
                        gray_model[idx]  = beat.gray_value;
                        res.stored       = 1'b1;
                    end
                end
            end
            MODE_CLR_GRAY:
            begin
                for (int i = 0; i < w * h; i++)
                    gray_model[i] = '0;
            end
            MODE_CLR_DEPTH:
            begin
                for (int i = 0; i < w * h; i++)
                    depth_model[i] = DEPTH_FAR;
            end
            default:
            begin
                if (x < 0 || x >= w || y < 0 || y + 1 >= h)
                begin
                    res.status = 1'b1;
                end
                else
                begin
                    idx             = y * w + x;
                    res.top_code    = ramp_code(gray_model[idx]);
                    res.bottom_code = ramp_code(gray_model[idx + w]);
                end
            end
        endcase
        return res;
    endfunction

    // random gaps per profile
    function automatic bit sender_gap();
        case (pace)
            PACE_RECV_HEAVY: return $urandom_range(99) < 28;
            PACE_SEND_HEAVY: return $urandom_range(99) < 60;
            default:         return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (pace)
            PACE_RECV_HEAVY: return $urandom_range(99) < 60;
            PACE_SEND_HEAVY: return $urandom_range(99) < 28;
            default:         return 1'b0;
        endcase
    endfunction

    // random beat, mostly in-frame so the depth test and reads see real data
    function automatic zgfs_in_t random_beat();
        zgfs_in_t b;
        int       w;
        int       h;
        int       x;
        int       y;
        int       pick;
        w    = cols_in_use();
        h    = rows_in_use();
        pick = $urandom_range(99);
        if (pick < 52)
            b.mode = MODE_WRITE;
        else if (pick < 82)
            b.mode = MODE_READ;
        else if (pick < 91)
            b.mode = MODE_CLR_GRAY;
        else
            b.mode = MODE_CLR_DEPTH;
        // a clear of a frame over BIG_FRAME entries is a long sweep, keep those rare
        if ((b.mode == MODE_CLR_GRAY || b.mode == MODE_CLR_DEPTH) && w * h > BIG_FRAME)
        begin
            if (big_clears_left > 0)
                big_clears_left--;
            else
                b.mode = MODE_WRITE;
        end
        pick = $urandom_range(99);
        if (pick < 80 && w > 0 && h > 0)
        begin
            x = $urandom_range(w - 1);
            y = $urandom_range(h - 1);
        end
        else if (pick < 92)
        begin
            case ($urandom_range(3))
                0:       x = -1;
                1:       x = w;
                2:       x = (w > 0) ? w - 1 : 0;
                default: x = 0;
            endcase
            case ($urandom_range(3))
                0:       y = -1;
                1:       y = h;
                2:       y = (h > 0) ? h - 1 : 0;
                default: y = 0;
            endcase
        end
        else
        begin
            x = $urandom_range(16'hFFFF);
            y = $urandom_range(16'hFFFF);
        end
        b.pos_x = POS_BITS'(x);
        b.pos_y = POS_BITS'(y);
        pick = $urandom_range(99);
        if (pick < 40)
            b.pixel_depth = PIXEL_DEPTH_BITS'($urandom_range(15));
        else if (pick < 75)
            b.pixel_depth = PIXEL_DEPTH_BITS'($urandom);
        else if (pick < 85)
            b.pixel_depth = DEPTH_FAR;
        else if (pick < 90)
            b.pixel_depth = DEPTH_FAR - 1'b1;
        else
            b.pixel_depth = PIXEL_DEPTH_BITS'($urandom_range(255));
        b.gray_value = GRAY_BITS'($urandom);
        return b;
    endfunction

    task automatic queue_beat(input zgfs_in_t b);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push_beat(input zgfs_mode_t m, input int x, input int y,
                             input int d, input int g);
        zgfs_in_t b;
        b.mode        = m;
        b.pos_x       = POS_BITS'(x);
        b.pos_y       = POS_BITS'(y);
        b.pixel_depth = PIXEL_DEPTH_BITS'(d);
        b.gray_value  = GRAY_BITS'(g);
        queue_beat(b);
    endtask

    // wait until every queued beat is accepted and answered
    task automatic wait_drained();
        while (beats_accepted != beats_queued || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_frame_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FRAME_WIDTH)
            cfg_width = value & ((1 << CFG_WIDTH_BITS) - 1);
        else
            cfg_height = value & ((1 << CFG_HEIGHT_BITS) - 1);
    endtask

    // one frame size with a batch of random beats
    task automatic run_phase(input int w_reg, input int h_reg, input int count);
        wait_drained();
        write_frame_reg(CFG_FRAME_WIDTH, w_reg);
        write_frame_reg(CFG_FRAME_HEIGHT, h_reg);
        big_clears_left = 2;
        for (int i = 0; i < count; i++)
            queue_beat(random_beat());
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // input driver: predict on accept, then offer the next beat
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            expected_results.push_back(apply_to_frame(in_data));
            beats_accepted++;
        end
        if (!in_valid || !in_stall)
        begin
            if (pending_beats.size() != 0 && !sender_gap())
            begin
                in_valid <= 1'b1;
                in_data  <= pending_beats.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin : result_monitor
        zgfs_out_t want;
        int        hold_left;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result expected none actual %p", $time, out_data);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("stored", want.stored, out_data.stored);
                check_field("top_code", want.top_code, out_data.top_code);
                check_field("bottom_code", want.bottom_code, out_data.bottom_code);
            end
        end
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= receiver_gap();
        end
    end

    // run time limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("zbuffered_gray_frame_store: mismatch");
            $finish;
        end
    end

    // sequencer
    initial
    begin
        for (int i = 0; i < STORE_SIZE; i++)
        begin
            gray_model[i]  = '0;
            depth_model[i] = DEPTH_FAR;
        end
        cfg_width  = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed beats at the full default frame
        write_frame_reg(CFG_FRAME_WIDTH, MAX_WIDTH);
        write_frame_reg(CFG_FRAME_HEIGHT, MAX_HEIGHT);
        push_beat(MODE_READ, 0, 0, 0, 0);
        push_beat(MODE_WRITE, 0, 0, 0, 255);
        // equal depth does not pass
        push_beat(MODE_WRITE, 0, 0, 0, 7);
        push_beat(MODE_WRITE, 255, 127, 24'hFFFFFE, 128);
        // farthest depth never stores
        push_beat(MODE_WRITE, 255, 126, 24'hFFFFFF, 200);
        push_beat(MODE_WRITE, 0, 1, 100, 12);
        push_beat(MODE_WRITE, 1, 0, 100, 11);
        push_beat(MODE_WRITE, -1, 0, 3, 9);
        push_beat(MODE_WRITE, 0, -32768, 3, 9);
        push_beat(MODE_WRITE, 32767, 0, 3, 9);
        push_beat(MODE_WRITE, 256, 0, 3, 9);
        push_beat(MODE_WRITE, 0, 128, 3, 9);
        push_beat(MODE_READ, 0, 0, 0, 0);
        push_beat(MODE_READ, 1, 0, 24'hFFFFFF, 255);
        push_beat(MODE_READ, 255, 126, 0, 0);
        // pair would reach past the last row
        push_beat(MODE_READ, 255, 127, 0, 0);
        push_beat(MODE_READ, -1, 0, 0, 0);
        push_beat(MODE_READ, 256, 0, 0, 0);
        push_beat(MODE_READ, -32768, -1, 0, 0);
        push_beat(MODE_CLR_GRAY, 0, 0, 0, 0);
        push_beat(MODE_READ, 0, 0, 0, 0);
        // depth still held after a gray clear
        push_beat(MODE_WRITE, 0, 0, 5, 40);
        push_beat(MODE_CLR_DEPTH, 0, 0, 0, 0);
        push_beat(MODE_WRITE, 0, 0, 24'hFFFFFE, 1);
        push_beat(MODE_READ, 0, 0, 0, 0);

        // receiver heavy, with one long hold-off at the start
        pace = PACE_RECV_HEAVY;
        run_phase(4, 4, 150);
        hold_request = 300;
        run_phase(1, 1, 40);
        run_phase(0, 7, 30);
        run_phase(16, 8, 200);
        run_phase(511, 255, 120);

        // sender heavy
        wait_drained();
        pace = PACE_SEND_HEAVY;
        run_phase(2, 2, 100);
        run_phase(9, 0, 30);
        run_phase(3, 128, 120);
        run_phase(37, 13, 200);
        run_phase(256, 1, 80);

        // no idling
        wait_drained();
        pace = PACE_FREE;
        run_phase(8, 3, 160);
        run_phase(256, 128, 120);
        run_phase(5, 6, 180);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("zbuffered_gray_frame_store: match");
        else
            $display("zbuffered_gray_frame_store: mismatch");
        $finish;
    end

endmodule
